@@ hdl/binary_to_decimal_ascii_units_unit_macros.svh @@
//------------------------------------------------------------------------------
// binary_to_decimal_ascii_units_unit_macros.svh
// Assertion macros shared by the decimal text converter
//------------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_UNITS_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_UNITS_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BDAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BDAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bdau_pkg.sv @@
//------------------------------------------------------------------------------
// bdau_pkg
// Types and constants for the decimal text converter
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdau_pkg;

  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 7;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int CNT_W   = $clog2(VALUE_W);
  localparam int DCNT_W  = $clog2(DIGITS + 1);
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // register index (byte address / 4)
  localparam logic REG_UNIT_SCALING = 1'b0;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_G     = 7'h47;
  localparam logic [CHAR_W-1:0] CH_M     = 7'h4D;
  localparam logic [CHAR_W-1:0] CH_K     = 7'h4B;
  localparam logic [CHAR_W-1:0] CH_B     = 7'h42;

  typedef enum logic [1:0] {
    UNIT_B,
    UNIT_KB,
    UNIT_MB,
    UNIT_GB
  } unit_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_DIG,
    S_SPACE,
    S_PREFIX,
    S_BYTE
  } state_t;

endpackage

`default_nettype wire

@@ hdl/bdau_if.sv @@
//------------------------------------------------------------------------------
// bdau_if
// Valid/ready channels for values in and characters out
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bdau_num_if import bdau_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface bdau_char_if import bdau_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last_char;

  modport source(output valid, output text_char, output last_char, input ready);
  modport sink(input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

@@ hdl/binary_to_decimal_ascii_units_unit.sv @@
//------------------------------------------------------------------------------
// binary_to_decimal_ascii_units_unit
// 32-bit unsigned value to decimal ascii text, optional B/KB/MB/GB suffix
//------------------------------------------------------------------------------
// channel   dir  payload               handshake
// num       in   value[31:0]           valid/ready
// text      out  text_char, last_char  valid/ready
// apb       cfg  unit_scaling at 0x0   psel/penable/pwrite, pready tied high
//
// a request is accepted in idle, then double dabble shifts in all 32 value bits,
// then leading zero digits are dropped, one per cycle, then one character goes
// out per cycle as the output register frees up.
// rst clears the sequencer and the output valid flag and sets unit_scaling to 1.
// a stall on text holds the sequencer; num is taken again once idle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "binary_to_decimal_ascii_units_unit_macros.svh"

module binary_to_decimal_ascii_units_unit import bdau_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  bdau_num_if.sink               num,
  bdau_char_if.source            text
);

  state_t              state, state_next;
  logic                unit_scaling;
  unit_t               unit;
  logic [VALUE_W-1:0]  bin;
  logic [BCD_W-1:0]    bcd;
  logic [BCD_W-1:0]    bcd_adj;
  logic [CNT_W-1:0]    bit_cnt;
  logic [DCNT_W-1:0]   dig_cnt;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;
  logic                accept;
  logic                emit;
  logic                load;
  logic [CHAR_W-1:0]   char_val;
  logic                char_last;
  logic                skip_zero;
  unit_t               unit_sel;
  logic [VALUE_W-1:0]  bin_sel;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_UNIT_SCALING) ? {{(DATA_W-1){1'b0}}, unit_scaling}
                                                : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_scaling <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_UNIT_SCALING) begin
      unit_scaling <= pwdata[0];
    end
  end

  // input handshake
  assign num.ready = (state == S_IDLE);
  assign accept    = num.valid && num.ready;

  // unit pick and pre-scale by shifting
  always_comb begin
    unit_sel = UNIT_B;
    bin_sel  = num.value;
    if (unit_scaling) begin
      if (num.value[31:30] != '0) begin
        unit_sel = UNIT_GB;
        bin_sel  = {30'd0, num.value[31:30]};
      end else if (num.value[31:20] != '0) begin
        unit_sel = UNIT_MB;
        bin_sel  = {20'd0, num.value[31:20]};
      end else if (num.value[31:10] != '0) begin
        unit_sel = UNIT_KB;
        bin_sel  = {10'd0, num.value[31:10]};
      end
    end
  end

  // add-3 correction on each bcd digit before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3
                                                  : bcd[4*i +: 4];
    end
  end

  assign skip_zero = (bcd[BCD_W-1 -: 4] == 4'd0) && (dig_cnt > DCNT_W'(1));
  assign emit      = (state == S_DIG) || (state == S_SPACE) ||
                     (state == S_PREFIX) || (state == S_BYTE);
  assign load      = emit && (!out_valid || text.ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_CONV;
      end
      S_CONV: begin
        if (bit_cnt == CNT_W'(VALUE_W - 1)) state_next = S_SKIP;
      end
      S_SKIP: begin
        if (!skip_zero) state_next = S_DIG;
      end
      S_DIG: begin
        if (load && dig_cnt == DCNT_W'(1)) begin
          state_next = unit_scaling ? S_SPACE : S_IDLE;
        end
      end
      S_SPACE: begin
        if (load) state_next = (unit == UNIT_B) ? S_BYTE : S_PREFIX;
      end
      S_PREFIX: begin
        if (load) state_next = S_BYTE;
      end
      S_BYTE: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // character for the current state
  always_comb begin
    char_val  = CH_B;
    char_last = 1'b0;
    unique case (state)
      S_DIG: begin
        char_val  = CH_ZERO + {3'd0, bcd[BCD_W-1 -: 4]};
        char_last = !unit_scaling && (dig_cnt == DCNT_W'(1));
      end
      S_SPACE:  char_val = CH_SPACE;
      S_PREFIX: begin
        case (unit)
          UNIT_GB: char_val = CH_G;
          UNIT_MB: char_val = CH_M;
          default: char_val = CH_K;
        endcase
      end
      S_BYTE:   char_last = 1'b1;
      default:  char_val = CH_B;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath shift registers and counters
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          bin     <= bin_sel;
          unit    <= unit_sel;
          bcd     <= '0;
          bit_cnt <= '0;
          dig_cnt <= DCNT_W'(DIGITS);
        end
      end
      S_CONV: begin
        bcd     <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
        bin     <= {bin[VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + CNT_W'(1);
      end
      S_SKIP: begin
        if (skip_zero) begin
          bcd     <= {bcd[BCD_W-5:0], 4'd0};
          dig_cnt <= dig_cnt - DCNT_W'(1);
        end
      end
      S_DIG: begin
        if (load) begin
          bcd     <= {bcd[BCD_W-5:0], 4'd0};
          dig_cnt <= dig_cnt - DCNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_val;
      out_last <= char_last;
    end
  end

  assign text.valid     = out_valid;
  assign text.text_char = out_char;
  assign text.last_char = out_last;

  // checks
  `BDAU_ASSERT_SAME(a_digit_decimal, state == S_DIG, bcd[BCD_W-1 -: 4] <= 4'd9, "bad digit")
  `BDAU_ASSERT_SAME(a_digit_left, state == S_DIG || state == S_SKIP, dig_cnt != '0, "no digit")
  `BDAU_ASSERT_NEXT(a_accept_conv, accept, state == S_CONV && bit_cnt == '0, "no conv start")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
//------------------------------------------------------------------------------
// testbench
// Checks the decimal text converter, with and without size units
//------------------------------------------------------------------------------
// values go in on the num channel and every character that comes back on the
// text channel is checked against a predictor that works each value out to
// its text. a short table covers the unit boundaries, zero and the full
// range, then random values run in phases under both unit_scaling settings.
// the sender works in bursts and the receiver stalls on its own pattern,
// with one long receiver hold-off. unit_scaling is written and read back over
// apb only ahead of a table row or a phase, with the converter drained.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bdau_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 7;
  localparam int PHASES          = 4;
  localparam int VALUES_PER_PHASE = 75;
  localparam int DIRECTED_ROWS   = 20;
  localparam int SETTLE_CYCLES   = 4;
  localparam int END_CYCLES      = 60;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int MAX_REPORTS     = 10;

  localparam int STRAY_INDEX = 1;
  localparam logic [ADDR_W-1:0] UNIT_SCALING_ADDR = ADDR_W'(int'(REG_UNIT_SCALING) * 4);
  localparam logic [ADDR_W-1:0] STRAY_ADDR        = ADDR_W'(STRAY_INDEX * 4);

  localparam logic [VALUE_W-1:0] ONE_GB        = 32'h4000_0000;
  localparam logic [VALUE_W-1:0] ONE_MB        = 32'h0010_0000;
  localparam logic [VALUE_W-1:0] ONE_KB        = 32'h0000_0400;
  localparam logic [VALUE_W-1:0] DECIMAL_RADIX = 32'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_item_t;

  // optional config write ahead of the value; empty text means use the predictor
  typedef struct {
    bit                 cfg_wr;
    logic [ADDR_W-1:0]  cfg_addr;
    logic [DATA_W-1:0]  cfg_data;
    logic [VALUE_W-1:0] value;
    string              text;
  } directed_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bdau_num_if  num_ch ();
  bdau_char_if text_ch ();

  binary_to_decimal_ascii_units_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .num     (num_ch),
    .text    (text_ch)
  );

  text_item_t expected_text[$];
  logic       scaling_model;
  int         mismatches;
  int         values_sent;
  int         scaled_values;
  int         chars_checked;
  int         reg_reads;
  bit         hold_off_request;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // unit scaling after reset, stray register write must not disturb it
    '{1'b1, STRAY_ADDR,        32'h0000_0000, 32'd0,         "0 B"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd1,         "1 B"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd1023,      "1023 B"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd1024,      "1 KB"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd1048575,   "1023 KB"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd1048576,   "1 MB"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd1073741823, "1023 MB"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd1073741824, "1 GB"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'h8000_0000, "2 GB"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'hFFFF_FFFF, "3 GB"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd12345,     ""},
    // plain digits, only bit 0 of the written word counts
    '{1'b1, UNIT_SCALING_ADDR, 32'hFFFF_FFFE, 32'd0,         "0"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd9,         "9"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd10,        "10"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd1000000000, "1000000000"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'h8000_0000, "2147483648"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'hFFFF_FFFF, "4294967295"},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'd1234567890, ""},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'hAAAA_AAAA, ""},
    '{1'b0, UNIT_SCALING_ADDR, 32'h0000_0000, 32'h5555_5555, ""}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  // expected characters of one value under the current unit setting
  function automatic void predict_text(input logic [VALUE_W-1:0] value, input logic scaled);
    logic [VALUE_W-1:0] n;
    logic [CHAR_W-1:0]  chars[$];
    unit_t              unit;
    text_item_t         item;
    n = value;
    unit = UNIT_B;
    if (scaled) begin
      if (n >= ONE_GB) begin
        unit = UNIT_GB;
        n = n / ONE_GB;
      end else if (n >= ONE_MB) begin
        unit = UNIT_MB;
        n = n / ONE_MB;
      end else if (n >= ONE_KB) begin
        unit = UNIT_KB;
        n = n / ONE_KB;
      end
    end
    do begin
      chars.push_front(CH_ZERO + CHAR_W'(n % DECIMAL_RADIX));
      n = n / DECIMAL_RADIX;
    end while (n != 0);
    if (scaled) begin
      chars.push_back(CH_SPACE);
      case (unit)
        UNIT_GB: chars.push_back(CH_G);
        UNIT_MB: chars.push_back(CH_M);
        UNIT_KB: chars.push_back(CH_K);
        default: ;
      endcase
      chars.push_back(CH_B);
    end
    foreach (chars[i]) begin
      item.ch = chars[i];
      item.last = (i == chars.size() - 1);
      expected_text.push_back(item);
    end
  endfunction

  function automatic void push_typed_text(input string s);
    text_item_t item;
    byte        c;
    for (int i = 0; i < s.len(); i++) begin
      c = s.getc(i);
      item.ch = c[CHAR_W-1:0];
      item.last = (i == s.len() - 1);
      expected_text.push_back(item);
    end
  endfunction

  // random value leaning on unit boundaries, powers of ten and the top bit
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] base;
    int                 shift;
    shift = 10 * $urandom_range(1, 3);
    case ($urandom_range(0, 7))
      0, 1: return $urandom();
      2: return $urandom_range(0, 1023);
      3: return (VALUE_W'(1) << shift) + $urandom_range(0, 6) - 3;
      4: return (VALUE_W'($urandom_range(1, 1023)) << shift)
                | ($urandom() & ((VALUE_W'(1) << shift) - 1));
      5: begin
        base = 1;
        repeat ($urandom_range(0, 9)) base = base * DECIMAL_RADIX;
        return base + $urandom_range(0, 2) - 1;
      end
      6: return $urandom_range(0, 99999);
      default: return $urandom() | 32'h8000_0000;
    endcase
  endfunction

  // one apb transfer: setup cycle, then access cycle
  task automatic apb_transfer(input bit is_write, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write, update the model, read unit_scaling back
  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    apb_transfer(1'b1, addr, data, rd);
    if ((addr >> 2) == REG_UNIT_SCALING) begin
      scaling_model = data[0];
    end
    apb_transfer(1'b0, UNIT_SCALING_ADDR, '0, rd);
    reg_reads++;
    if (rd !== DATA_W'(scaling_model)) begin
      note_mismatch($sformatf("unit_scaling read: expected %0h, got %0h",
                              DATA_W'(scaling_model), rd));
    end
  endtask

  // offer one value and hold it until taken
  task automatic send_value(input logic [VALUE_W-1:0] value, input string typed_text);
    @(negedge clk);
    num_ch.valid <= 1'b1;
    num_ch.value <= value;
    do @(posedge clk); while (!num_ch.ready);
    values_sent++;
    if (scaling_model) begin
      scaled_values++;
    end
    if (typed_text.len() != 0) begin
      push_typed_text(typed_text);
    end else begin
      predict_text(value, scaling_model);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    num_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // character checker
  always @(posedge clk) begin : check_text
    text_item_t want;
    if (!rst && text_ch.valid && text_ch.ready) begin
      chars_checked++;
      if (expected_text.size() == 0) begin
        note_mismatch($sformatf("unexpected character %0h last %0b",
                                text_ch.text_char, text_ch.last_char));
      end else begin
        want = expected_text.pop_front();
        if (text_ch.text_char !== want.ch || text_ch.last_char !== want.last) begin
          note_mismatch($sformatf("character: expected %0h last %0b, got %0h last %0b",
                                  want.ch, want.last, text_ch.text_char, text_ch.last_char));
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin : text_receiver
    int mode;
    int stretch;
    text_ch.ready = 1'b0;
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          text_ch.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      stretch = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(5, 50);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0: text_ch.ready <= 1'b1;
          1: text_ch.ready <= $urandom_range(0, 1);
          2: text_ch.ready <= ($urandom_range(0, 3) == 0);
          default: text_ch.ready <= 1'b0;
        endcase
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready)
          || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("binary_to_decimal_ascii_units_unit: mismatch");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int burst_left;
    int gap;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    num_ch.valid = 1'b0;
    num_ch.value = '0;
    scaling_model = 1'b1;
    mismatches = 0;
    values_sent = 0;
    scaled_values = 0;
    chars_checked = 0;
    reg_reads = 0;
    hold_off_request = 1'b0;
    burst_left = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed table, back to back
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_wr) begin
        drain_results();
        write_register(directed_rows[i].cfg_addr, directed_rows[i].cfg_data);
      end
      send_value(directed_rows[i].value, directed_rows[i].text);
    end

    // random phases, alternating unit scaling on and off
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      write_register(UNIT_SCALING_ADDR,
                     {31'($urandom_range(0, 32'h7FFF_FFFF)), phase % 2 == 0});
      if (phase == 2) begin
        write_register(STRAY_ADDR, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0});
      end
      for (int k = 0; k < VALUES_PER_PHASE; k++) begin
        if (phase == 1 && k == 30) begin
          hold_off_request = 1'b1;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 10);
          gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
          if (gap != 0) begin
            @(negedge clk);
            num_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        send_value(random_value(), "");
        burst_left--;
      end
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    $display("converted %0d values: %0d with unit suffix, %0d as plain digits",
             values_sent, scaled_values, values_sent - scaled_values);
    $display("checked %0d characters and %0d register reads, %0d mismatches",
             chars_checked, reg_reads, mismatches);
    if (mismatches == 0) begin
      $display("binary_to_decimal_ascii_units_unit: match");
    end else begin
      $display("binary_to_decimal_ascii_units_unit: mismatch");
    end
    $finish;
  end

endmodule
